[hdl/xor_archive_stream_parser_defines.svh]
// assertion macros used by the checker file of the archive stream parser
// depends on nothing; included by bare file name
`ifndef XOR_ARCHIVE_STREAM_PARSER_DEFINES_SVH
`define XOR_ARCHIVE_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define XAP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is high
`define XAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[hdl/xap_pkg.sv]
// types and constants of the xor archive stream parser
// used by the front, queue, back, top level and checker; depends on nothing
`timescale 1ns / 1ps

package xap_pkg;

   // request payload: raw byte and end-of-archive mark
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } xap_req_type;

   // response payload: one tagged decoded byte
   typedef struct packed {
      logic [7:0]  out_byte;
      logic [3:0]  field_kind;
      logic [7:0]  record_index;
      logic        field_end;
      logic [31:0] record_size;
      logic [2:0]  status;
      logic        all_done;
   } xap_rsp_type;

   // decoded byte on its way from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } xap_item_type;

   // field kinds
   localparam logic [3:0] KIND_MAGIC    = 4'd0;
   localparam logic [3:0] KIND_VERSION  = 4'd1;
   localparam logic [3:0] KIND_FLAG     = 4'd2;
   localparam logic [3:0] KIND_NAME_LEN = 4'd3;
   localparam logic [3:0] KIND_NAME     = 4'd4;
   localparam logic [3:0] KIND_SIZE     = 4'd5;
   localparam logic [3:0] KIND_TIME     = 4'd6;
   localparam logic [3:0] KIND_BODY     = 4'd7;
   localparam logic [3:0] KIND_IGNORED  = 4'd8;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
   localparam logic [2:0] ST_BAD_VER   = 3'd2;
   localparam logic [2:0] ST_TRUNC     = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   // decode key after reset, header end flag, queue depth
   localparam logic [7:0] KEY_RESET   = 8'hF7;
   localparam logic [7:0] END_FLAG    = 8'h80;
   localparam int         QUEUE_DEPTH = 4;
   localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);

   // archive magic bytes in stream order
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'hC0;
         2'd1:    val = 8'h4A;
         2'd2:    val = 8'hC0;
         2'd3:    val = 8'hBA;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

[hdl/xor_archive_stream_parser.sv]
// top level of the xor archive stream parser
// depends on xap_pkg, xap_front, xap_fifo and xap_back
//
// Usage:
//   req_*  : one raw archive byte per transaction, last_byte marks the end
//   rsp_*  : one tagged decoded byte per request transaction, in order
//   csr_*  : writes the decode key (reset value 0xF7); write only when idle
// Path: a request accepted passes the decode stage register, then a queue
//   slot, then the parser response register before it shows on rsp_valid.
// Throughput: one transaction per cycle while rsp_ready does not stall the
//   response; the parser walks one byte per cycle and the size table is read
//   through its registered read port, prefetched by the entry counter.
// Reset clears the parser to the magic phase and the key to 0xF7; the
//   size table holds no reset value; only its written entries are used.
//   The last byte of an archive re-arms the parser but keeps the key.
// A stalled rsp_ready holds the response; the four-entry queue and the
//   decode stage keep taking requests until they fill, then req_ready drops.
`timescale 1ns / 1ps

module xor_archive_stream_parser
   import xap_pkg::*;
#(
   parameter int MAX_RECORDS = 256
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  xap_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output xap_rsp_type rsp_data
);

   logic         fq_valid;
   logic         fq_ready;
   xap_item_type fq_item;
   logic         qb_valid;
   logic         qb_ready;
   xap_item_type qb_item;

   // decode front
   xap_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_item    (fq_item)
   );

   // decoupling queue
   xap_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   // parser back
   xap_back #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (qb_valid),
      .q_ready   (qb_ready),
      .q_item    (qb_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/xap_front.sv]
// front end: decode key register, request accept and xor decode stage
// depends on xap_pkg
`timescale 1ns / 1ps

module xap_front
   import xap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  xap_req_type  req_data,
   output logic         q_valid,
   input  logic         q_ready,
   output xap_item_type q_item
);

   logic [7:0]   key_val_ff;
   logic         fr_valid_ff;
   xap_item_type fr_item_ff;
   logic         req_take;

   // key writes are always taken
   assign csr_ready = 1'b1;

   // stage frees up when empty or when the queue takes its transaction
   assign req_ready = !fr_valid_ff || q_ready;
   assign req_take  = req_valid && req_ready;
   assign q_valid   = fr_valid_ff;
   assign q_item    = fr_item_ff;

   // decode key register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_val_ff <= KEY_RESET;
      end else if (csr_valid) begin
         key_val_ff <= csr_data;
      end
   end

   // decode stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else if (req_take) begin
         fr_valid_ff <= 1'b1;
      end else if (q_ready) begin
         fr_valid_ff <= 1'b0;
      end
   end

   // decode stage payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         fr_item_ff.data <= req_data.in_byte ^ key_val_ff;
         fr_item_ff.last <= req_data.last_byte;
      end
   end

endmodule

[hdl/xap_fifo.sv]
// short queue between decode front and parser back
// depends on xap_pkg for the item type and queue depth
`timescale 1ns / 1ps

module xap_fifo
   import xap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  xap_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output xap_item_type pop_item
);

   xap_item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff;
   logic [QPTR_W-1:0]       rd_ptr_ff;
   logic [QPTR_W:0]         count_ff;
   logic                    push;
   logic                    pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (QPTR_W+1)'(1);
            2'b01:   count_ff <= count_ff - (QPTR_W+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/xap_back.sv]
// back end: header walker, size table and response register
// depends on xap_pkg
`timescale 1ns / 1ps

module xap_back
   import xap_pkg::*;
#(
   parameter int MAX_RECORDS = 256
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_ready,
   input  xap_item_type q_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output xap_rsp_type  rsp_data
);

   localparam int FILL_W      = $clog2(MAX_RECORDS + 1);
   localparam int ADDR_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int TABLE_DEPTH = 1 << ADDR_W;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_VERSION,
      PH_FLAG,
      PH_NAME_LEN,
      PH_NAME,
      PH_SIZE,
      PH_TIME,
      PH_BODY,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef struct packed {
      logic [31:0] size;
      logic [7:0]  rec;
   } entry_type;

   phase_type         phase_ff,     phase_in;
   logic [2:0]        fcnt_ff,      fcnt_in;
   logic [7:0]        name_left_ff, name_left_in;
   logic [31:0]       size_acc_ff,  size_acc_in;
   logic [7:0]        rec_cnt_ff,   rec_cnt_in;
   logic [FILL_W-1:0] fill_ff,      fill_in;
   logic [FILL_W-1:0] entry_ff,     entry_in;
   logic [31:0]       body_cnt_ff,  body_cnt_in;
   logic [2:0]        err_ff,       err_in;
   logic              rsp_valid_ff;
   xap_rsp_type       rsp_data_ff,  rsp_in;

   entry_type         table_mem [TABLE_DEPTH];
   entry_type         rd_q_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              step;

   logic [7:0]        b;
   logic              magic_ph;
   logic [7:0]        want;
   logic [7:0]        nl_dec;
   logic [31:0]       acc_new;
   logic [FILL_W-1:0] entry_inc;
   logic [3:0]        kind;
   logic [7:0]        rec;
   logic              fend;
   logic [31:0]       rsize;
   logic [2:0]        status;
   logic              done;

   // one transaction per cycle while the response slot is free or draining
   assign step      = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_ready   = step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign b         = q_item.data;
   assign magic_ph  = (phase_ff == PH_MAGIC);
   assign want      = magic_ph ? magic_byte(fcnt_ff[1:0]) : 8'h00;
   assign nl_dec    = (name_left_ff != 8'd0) ? (name_left_ff - 8'd1) : 8'd0;
   assign entry_inc = entry_ff + FILL_W'(1);

   // size byte merged into the little-endian accumulator
   always_comb begin
      acc_new = size_acc_ff;
      acc_new[{fcnt_ff[1:0], 3'b000} +: 8] = size_acc_ff[{fcnt_ff[1:0], 3'b000} +: 8] | b;
   end

   // parser next state and response for the transaction at the queue head
   always_comb begin
      phase_in     = phase_ff;
      fcnt_in      = fcnt_ff;
      name_left_in = name_left_ff;
      size_acc_in  = size_acc_ff;
      rec_cnt_in   = rec_cnt_ff;
      fill_in      = fill_ff;
      entry_in     = entry_ff;
      body_cnt_in  = body_cnt_ff;
      err_in       = err_ff;
      wr_en        = 1'b0;
      kind         = KIND_IGNORED;
      rec          = 8'd0;
      fend         = 1'b0;
      rsize        = 32'd0;

      case (phase_ff)
         PH_MAGIC, PH_VERSION: begin
            kind = magic_ph ? KIND_MAGIC : KIND_VERSION;
            fend = (fcnt_ff == 3'd3);
            if (b != want) begin
               err_in   = magic_ph ? ST_BAD_MAGIC : ST_BAD_VER;
               phase_in = PH_FAIL;
            end else if (fcnt_ff == 3'd3) begin
               fcnt_in  = 3'd0;
               phase_in = magic_ph ? PH_VERSION : PH_FLAG;
            end else begin
               fcnt_in = fcnt_ff + 3'd1;
            end
         end
         PH_FLAG: begin
            kind        = KIND_FLAG;
            fend        = 1'b1;
            rec         = rec_cnt_ff;
            size_acc_in = 32'd0;
            if (b == END_FLAG) begin
               entry_in    = '0;
               body_cnt_in = 32'd0;
               phase_in    = (fill_ff == '0) ? PH_DONE : PH_BODY;
            end else begin
               phase_in = PH_NAME_LEN;
            end
         end
         PH_NAME_LEN: begin
            kind         = KIND_NAME_LEN;
            fend         = 1'b1;
            rec          = rec_cnt_ff;
            rsize        = size_acc_ff;
            name_left_in = b;
            fcnt_in      = 3'd0;
            phase_in     = (b == 8'd0) ? PH_SIZE : PH_NAME;
         end
         PH_NAME: begin
            kind         = KIND_NAME;
            rec          = rec_cnt_ff;
            rsize        = size_acc_ff;
            name_left_in = nl_dec;
            if (nl_dec == 8'd0) begin
               fend     = 1'b1;
               fcnt_in  = 3'd0;
               phase_in = PH_SIZE;
            end
         end
         PH_SIZE: begin
            kind        = KIND_SIZE;
            rec         = rec_cnt_ff;
            size_acc_in = acc_new;
            rsize       = acc_new;
            if (fcnt_ff == 3'd3) begin
               fend     = 1'b1;
               fcnt_in  = 3'd0;
               phase_in = PH_TIME;
               if (acc_new != 32'd0) begin
                  if (fill_ff == FILL_W'(MAX_RECORDS)) begin
                     err_in   = ST_OVERFLOW;
                     phase_in = PH_FAIL;
                  end else begin
                     wr_en   = 1'b1;
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end else begin
               fcnt_in = fcnt_ff + 3'd1;
            end
         end
         PH_TIME: begin
            kind  = KIND_TIME;
            rec   = rec_cnt_ff;
            rsize = size_acc_ff;
            if (fcnt_ff == 3'd7) begin
               fend       = 1'b1;
               fcnt_in    = 3'd0;
               rec_cnt_in = rec_cnt_ff + 8'd1;
               phase_in   = PH_FLAG;
            end else begin
               fcnt_in = fcnt_ff + 3'd1;
            end
         end
         PH_BODY: begin
            kind  = KIND_BODY;
            rec   = rd_q_ff.rec;
            rsize = rd_q_ff.size;
            if (body_cnt_ff == (rd_q_ff.size - 32'd1)) begin
               fend        = 1'b1;
               entry_in    = entry_inc;
               body_cnt_in = 32'd0;
               if (entry_inc >= fill_ff) begin
                  phase_in = PH_DONE;
               end
            end else begin
               body_cnt_in = body_cnt_ff + 32'd1;
            end
         end
         default: begin
         end
      endcase

      // status after this transaction, truncation shown on the last byte
      done   = (phase_in == PH_DONE);
      status = err_in;
      if (q_item.last && (status == ST_OK) && !done) begin
         status = ST_TRUNC;
      end

      rsp_in.out_byte     = b;
      rsp_in.field_kind   = kind;
      rsp_in.record_index = rec;
      rsp_in.field_end    = fend;
      rsp_in.record_size  = rsize;
      rsp_in.status       = status;
      rsp_in.all_done     = done;

      // last byte re-arms the walker, key is kept in the front
      if (q_item.last) begin
         phase_in     = PH_MAGIC;
         fcnt_in      = 3'd0;
         name_left_in = 8'd0;
         size_acc_in  = 32'd0;
         rec_cnt_in   = 8'd0;
         fill_in      = '0;
         entry_in     = '0;
         body_cnt_in  = 32'd0;
         err_in       = ST_OK;
      end
   end

   // table read follows the entry the next body byte will need
   assign rd_addr = step ? entry_in[ADDR_W-1:0] : entry_ff[ADDR_W-1:0];

   // size table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (step && wr_en) begin
         table_mem[fill_ff[ADDR_W-1:0]] <= '{size: acc_new, rec: rec_cnt_ff};
      end
      rd_q_ff <= table_mem[rd_addr];
   end

   // walker state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         fcnt_ff      <= 3'd0;
         name_left_ff <= 8'd0;
         size_acc_ff  <= 32'd0;
         rec_cnt_ff   <= 8'd0;
         fill_ff      <= '0;
         entry_ff     <= '0;
         body_cnt_ff  <= 32'd0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            fcnt_ff      <= fcnt_in;
            name_left_ff <= name_left_in;
            size_acc_ff  <= size_acc_in;
            rec_cnt_ff   <= rec_cnt_in;
            fill_ff      <= fill_in;
            entry_ff     <= entry_in;
            body_cnt_ff  <= body_cnt_in;
            err_ff       <= err_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

[hdl/xap_checker.sv]
// port-level checks of the xor archive stream parser and their bind
// depends on xap_pkg and xor_archive_stream_parser_defines.svh
`timescale 1ns / 1ps
`include "xor_archive_stream_parser_defines.svh"

module xap_checker
   import xap_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input xap_rsp_type rsp_data
);

   // stalled response holds
   `XAP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // a finished archive never carries an error
   `XAP_ASSERT_IMPLY(a_done_ok, clock, reset, rsp_valid && rsp_data.all_done, rsp_data.status == ST_OK)

   // ignored bytes carry no record information
   `XAP_ASSERT_IMPLY(a_ignored_clean, clock, reset, rsp_valid && (rsp_data.field_kind == KIND_IGNORED), !rsp_data.field_end && (rsp_data.record_index == 8'd0) && (rsp_data.record_size == 32'd0))

   // body bytes only belong to records with a non-zero size
   `XAP_ASSERT_IMPLY(a_body_sized, clock, reset, rsp_valid && (rsp_data.field_kind == KIND_BODY), rsp_data.record_size != 32'd0)

endmodule

bind xor_archive_stream_parser xap_checker u_xap_checker (.*);
